>>> rtl/ssd_pkg.sv
// Package for the sample standard deviation block.
// Holds widths, limits and the job/result structs shared by ssd_core and the top level.
// No dependencies.
package ssd_pkg;

    // Largest group is 2^COUNT_LOG2 present samples
    localparam int COUNT_LOG2 = 16;
    localparam int CNT_W      = COUNT_LOG2 + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1) << COUNT_LOG2;

    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 40;
    localparam int SQ_W     = 64;
    localparam int STD_W    = 23;

    // Datapath widths of the finishing unit
    localparam int PROD_W = CNT_W + SQ_W;      // n*S2 and S1*S1
    localparam int DIV_W  = 2 * CNT_W;         // n*(n-1)
    localparam int ROOT_W = STD_W + 1;
    localparam int VAR_W  = 2 * ROOT_W;        // variance fits below 2^48
    localparam int REM_W  = (DIV_W > ROOT_W + 2) ? DIV_W : ROOT_W + 2;
    localparam int ITER_W = $clog2(PROD_W);

    localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};

    // Group totals handed to the finishing unit
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [CNT_W-1:0] cnt;
    } t_ssd_job;

    // Finished result from the finishing unit
    typedef struct packed {
        logic             done;
        logic [STD_W-1:0] std_dev;
        logic             valid_res;
    } t_ssd_res;

endpackage

>>> rtl/ssd_if.sv
// Request channels of the sample standard deviation block.
// Input samples and output results, each with valid/ready; depends on nothing.
interface ssd_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] sample;
    logic        is_missing;
    logic        last;

    modport source (output valid, output sample, output is_missing, output last, input ready);
    modport sink   (input valid, input sample, input is_missing, input last, output ready);
endinterface

interface ssd_out_if;
    logic        valid;
    logic        ready;
    logic [22:0] std_dev;
    logic        valid_res;
    logic        overflow;

    modport source (output valid, output std_dev, output valid_res, output overflow, input ready);
    modport sink   (input valid, input std_dev, input valid_res, input overflow, output ready);
endinterface

>>> rtl/ssd_core.sv
// Finishing unit: sqrt((n*S2 - S1^2) / (n*(n-1))); n*(n-1) is a plain multiply, the rest runs over one
// shared adder/subtractor: shift-add multiplies, restoring divide and digit-by-digit root in turn. Uses ssd_pkg.
module ssd_core import ssd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_ssd_job i_job,
    input  logic     i_take,
    output t_ssd_res o_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MULB = 3'd2;
    localparam logic [2:0] ST_MULA = 3'd3;
    localparam logic [2:0] ST_DIFF = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_SQRT = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]        r_state;
    logic [ITER_W-1:0] r_iter;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sq;
    logic [CNT_W-1:0]  r_n;
    logic [DIV_W-1:0]  r_d;
    logic [SUM_W-1:0]  r_mplier;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_b;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic              r_valid_res;

    // Shared adder/subtractor
    logic [PROD_W-1:0] alu_a;
    logic [PROD_W-1:0] alu_b;
    logic              alu_sub;
    logic [PROD_W-1:0] alu_sum;
    logic              alu_co;

    logic [DIV_W:0]    div_trial;
    logic [REM_W-1:0]  sqrt_trial;
    logic [PROD_W-1:0] mcand;

    assign div_trial  = {r_rem[DIV_W-1:0], r_acc[PROD_W-1]};
    assign sqrt_trial = {r_rem[REM_W-3:0], r_acc[VAR_W-1 -: 2]};
    assign mcand      = (r_state == ST_MULB) ? PROD_W'(r_sum) : PROD_W'(r_sq);

    // Pick operands for the current step
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            ST_PREP: begin
                alu_b   = PROD_W'(r_sum);
                alu_sub = 1'b1;
            end
            ST_MULB, ST_MULA: begin
                alu_a = {r_acc[PROD_W-2:0], 1'b0};
                alu_b = r_mplier[SUM_W-1] ? mcand : '0;
            end
            ST_DIFF: begin
                alu_a   = r_acc;
                alu_b   = r_b;
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a   = PROD_W'(div_trial);
                alu_b   = PROD_W'(r_d);
                alu_sub = 1'b1;
            end
            ST_SQRT: begin
                alu_a   = PROD_W'(sqrt_trial);
                alu_b   = PROD_W'({r_root, 2'b01});
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
            end
        endcase
    end

    assign {alu_co, alu_sum} = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                             + (PROD_W+1)'(alu_sub);

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_sum       <= i_job.sum;
                        r_sq        <= i_job.sq;
                        r_n         <= i_job.cnt;
                        r_root      <= '0;
                        r_valid_res <= (i_job.cnt >= CNT_W'(2));
                        r_state     <= (i_job.cnt >= CNT_W'(2)) ? ST_PREP : ST_DONE;
                    end
                end
                ST_PREP: begin
                    // Take the magnitude of the sum and form n*(n-1)
                    r_sum    <= r_sum[SUM_W-1] ? alu_sum[SUM_W-1:0] : r_sum;
                    r_mplier <= r_sum[SUM_W-1] ? alu_sum[SUM_W-1:0] : r_sum;
                    r_d      <= DIV_W'(r_n) * DIV_W'(r_n - CNT_W'(1));
                    r_acc    <= '0;
                    r_iter   <= ITER_W'(SUM_W - 1);
                    r_state  <= ST_MULB;
                end
                ST_MULB: begin
                    r_acc    <= alu_sum;
                    r_mplier <= {r_mplier[SUM_W-2:0], 1'b0};
                    r_iter   <= r_iter - ITER_W'(1);
                    if (r_iter == '0) begin
                        r_b      <= alu_sum;
                        r_acc    <= '0;
                        r_mplier <= {r_n, {(SUM_W-CNT_W){1'b0}}};
                        r_iter   <= ITER_W'(CNT_W - 1);
                        r_state  <= ST_MULA;
                    end
                end
                ST_MULA: begin
                    r_acc    <= alu_sum;
                    r_mplier <= {r_mplier[SUM_W-2:0], 1'b0};
                    r_iter   <= r_iter - ITER_W'(1);
                    if (r_iter == '0) begin
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    // Clamp a negative numerator to zero
                    r_acc   <= alu_co ? alu_sum : '0;
                    r_rem   <= '0;
                    r_iter  <= ITER_W'(PROD_W - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem  <= alu_co ? REM_W'(alu_sum[DIV_W-1:0])
                                     : REM_W'(div_trial[DIV_W-1:0]);
                    r_acc  <= {r_acc[PROD_W-2:0], alu_co};
                    r_iter <= r_iter - ITER_W'(1);
                    if (r_iter == '0) begin
                        r_state <= ST_SQRT;
                        r_iter  <= ITER_W'(ROOT_W - 1);
                    end
                end
                ST_SQRT: begin
                    r_rem  <= alu_co ? alu_sum[REM_W-1:0] : sqrt_trial;
                    r_root <= {r_root[ROOT_W-2:0], alu_co};
                    r_acc  <= {r_acc[PROD_W-3:0], 2'b00};
                    r_iter <= r_iter - ITER_W'(1);
                    if (r_iter == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (r_state == ST_DIFF || (r_state == ST_DIV && r_iter == '0)) begin
                r_root <= '0;
            end
            if (r_state == ST_DIV && r_iter == '0) begin
                r_rem <= '0;
            end
        end
    end

    // Hold the result, saturated to the output range
    assign o_res.done      = (r_state == ST_DONE);
    assign o_res.std_dev   = r_root[ROOT_W-1] ? STD_MAX : r_root[STD_W-1:0];
    assign o_res.valid_res = r_valid_res;

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state != ST_IDLE))
        else $error("finishing unit ignored a start");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (REM_W'(r_rem) < REM_W'(r_d)))
        else $error("divider remainder not below divisor");

    a_sqrt_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> (r_rem <= REM_W'({r_root, 1'b0})))
        else $error("root remainder above twice the partial root");

endmodule

>>> rtl/sample_std_deviation.sv
// Sample standard deviation over groups of signed Q12.12 samples.
//
// Input channel i_in carries one sample request per cycle with is_missing
// and last flags; output channel o_out carries one result per group.
// Present samples are summed, squared and counted as they are accepted,
// one per cycle, while the block is not finishing a group. Past
// 2^COUNT_LOG2 present samples further ones are dropped and the result
// reports overflow.
// On the request marked last the totals go to ssd_core, which computes
// sqrt((n*S2 - S1^2) / (n*(n-1))) with one shared adder and, for n*(n-1),
// a multiplier: a setup step, 40 + 17 shift-add multiply steps, 1 subtract,
// 81 divide steps and 24 root steps. A group with fewer than two samples
// skips these steps. i_in.ready is low while a group is being finished.
// The result waits in an output register; a stalled receiver holds it and,
// once the next group finishes, the block waits for the slot, but new
// samples are still accepted while only the output register is full.
// Reset (i_rst_n low, synchronous) clears the totals and drops any result.
// Uses ssd_pkg, ssd_if and ssd_core.
module sample_std_deviation import ssd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssd_in_if.sink        i_in,
    ssd_out_if.source     o_out
);

    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sq;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;
    logic              r_busy;
    logic              r_job_ovf;
    logic              r_out_valid;
    logic [STD_W-1:0]  r_out_std;
    logic              r_out_vres;
    logic              r_out_ovf;

    logic [SUM_W-1:0]      n_sum;
    logic [SQ_W-1:0]       n_sq;
    logic [CNT_W-1:0]      n_cnt;
    logic                  n_ovf;
    logic                  in_acc;
    logic                  take;
    logic                  add_smp;
    logic [2*SAMPLE_W-1:0] smp_sq;
    t_ssd_job              job;
    t_ssd_res              res;

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = !r_busy;
    assign take     = !r_out_valid || o_out.ready;

    // Fold one present sample into the totals
    assign add_smp = !i_in.is_missing && (r_cnt != CNT_MAX);
    assign smp_sq  = (2*SAMPLE_W)'($signed(i_in.sample) * $signed(i_in.sample));
    assign n_sum   = add_smp ? r_sum + SUM_W'($signed(i_in.sample)) : r_sum;
    assign n_sq    = add_smp ? r_sq + SQ_W'(smp_sq) : r_sq;
    assign n_cnt   = add_smp ? r_cnt + CNT_W'(1) : r_cnt;
    assign n_ovf   = r_ovf || (!i_in.is_missing && (r_cnt == CNT_MAX));

    assign job.sum = n_sum;
    assign job.sq  = n_sq;
    assign job.cnt = n_cnt;

    ssd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && i_in.last),
        .i_job   (job),
        .i_take  (take),
        .o_res   (res)
    );

    // Accumulate samples; clear on the last request of a group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_sq   <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_in.last) begin
                    r_sum     <= '0;
                    r_sq      <= '0;
                    r_cnt     <= '0;
                    r_ovf     <= 1'b0;
                    r_busy    <= 1'b1;
                    r_job_ovf <= n_ovf;
                end else begin
                    r_sum <= n_sum;
                    r_sq  <= n_sq;
                    r_cnt <= n_cnt;
                    r_ovf <= n_ovf;
                end
            end
            if (res.done && take) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res.done && take) begin
                r_out_valid <= 1'b1;
                r_out_std   <= res.std_dev;
                r_out_vres  <= res.valid_res;
                r_out_ovf   <= r_job_ovf;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.std_dev   = r_out_std;
    assign o_out.valid_res = r_out_vres;
    assign o_out.overflow  = r_out_ovf;

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("sample count past its limit");

    a_last_starts_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> r_busy)
        else $error("last request did not start the finishing unit");

    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done |-> r_busy)
        else $error("finished result with no group in flight");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |-> (o_out.std_dev == '0))
        else $error("invalid result carries a nonzero value");

endmodule
